/* hdl/rpwp_pkg.sv */
`timescale 1ns / 1ps

package rpwp_pkg;

	// Array sizes
	localparam int TABLE_DEPTH = 64;
	localparam int CELL_COUNT  = 1024;

	localparam int TBL_AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CELL_AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
	localparam int PULSE_W = $clog2(TABLE_DEPTH + 1);

	// Fixed field widths
	localparam int REQ_W      = 2;
	localparam int TIDX_W     = 6;
	localparam int WEIGHT_W   = 16;
	localparam int ADDR_W     = 10;
	localparam int LEN_W      = 7;
	localparam int PULSES_W   = 7;
	localparam int TOTAL_W    = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Request codes
	localparam logic [REQ_W-1:0] REQ_LOAD_POT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_LOAD_DEP = 2'd1;
	localparam logic [REQ_W-1:0] REQ_UPDATE   = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_POT_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEP_LENGTH = 2'd1;

	localparam logic [LEN_W-1:0] LEN_RESET = 7'd1;

	typedef enum logic [1:0] {
		CMD_NOP,
		CMD_LOAD_POT,
		CMD_LOAD_DEP,
		CMD_UPDATE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t             kind;
		logic [TBL_AW-1:0]     idx;
		logic [WEIGHT_W-1:0]   value;
		logic [CELL_AW-1:0]    addr;
		logic [WEIGHT_W-1:0]   target;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} queue_head_t;

	typedef struct packed {
		logic pop;
		logic clearing;
	} back_stat_t;

	typedef struct packed {
		logic [LEN_W-1:0] pot_len;
		logic [LEN_W-1:0] dep_len;
	} len_cfg_t;

endpackage

/* hdl/rpwp_if.sv */
`timescale 1ns / 1ps

interface rpwp_req_if import rpwp_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [REQ_W-1:0]           req_type;
	logic [TIDX_W-1:0]          table_index;
	logic signed [WEIGHT_W-1:0] table_value;
	logic [ADDR_W-1:0]          cell_address;
	logic signed [WEIGHT_W-1:0] target_weight;

	modport source (output valid, req_type, table_index, table_value, cell_address,
		target_weight, input ready);
	modport sink (input valid, req_type, table_index, table_value, cell_address,
		target_weight, output ready);
endinterface

interface rpwp_rsp_if import rpwp_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [WEIGHT_W-1:0] weight_out;
	logic [PULSES_W-1:0]        pulses_applied;
	logic [TOTAL_W-1:0]         pulse_total;

	modport source (output valid, weight_out, pulses_applied, pulse_total, input ready);
	modport sink (input valid, weight_out, pulses_applied, pulse_total, output ready);
endinterface

interface rpwp_cfg_if import rpwp_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* hdl/rpwp_ram.sv */
`timescale 1ns / 1ps

module rpwp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hdl/rpwp_front.sv */
`timescale 1ns / 1ps

module rpwp_front import rpwp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	rpwp_req_if.sink    req,
	input  back_stat_t  stat,
	output queue_head_t head
);

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	cmd_t              cmd_in;
	logic              push;

	// Classify the request, dropping anything out of range to a no-op
	always_comb begin
		cmd_in.idx    = TBL_AW'(req.table_index);
		cmd_in.value  = req.table_value;
		cmd_in.addr   = CELL_AW'(req.cell_address);
		cmd_in.target = req.target_weight;
		unique case (req.req_type)
			REQ_LOAD_POT: cmd_in.kind = (32'(req.table_index) < 32'(TABLE_DEPTH)) ?
				CMD_LOAD_POT : CMD_NOP;
			REQ_LOAD_DEP: cmd_in.kind = (32'(req.table_index) < 32'(TABLE_DEPTH)) ?
				CMD_LOAD_DEP : CMD_NOP;
			REQ_UPDATE:   cmd_in.kind = (32'(req.cell_address) < 32'(CELL_COUNT)) ?
				CMD_UPDATE : CMD_NOP;
			default:      cmd_in.kind = CMD_NOP;
		endcase
	end

	assign req.ready  = (cnt_q != QCNT_W'(QUEUE_DEPTH)) && !stat.clearing;
	assign push       = req.valid && req.ready;
	assign head.valid = (cnt_q != '0);
	assign head.cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (stat.pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !stat.pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && stat.pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/rpwp_back.sv */
`timescale 1ns / 1ps

module rpwp_back import rpwp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  len_cfg_t    lens,
	input  queue_head_t head,
	output back_stat_t  stat,
	rpwp_rsp_if.source  rsp
);

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_FETCH = 6'b000100,
		ST_ORIG  = 6'b001000,
		ST_WALK  = 6'b010000,
		ST_DONE  = 6'b100000
	} back_state_t;

	back_state_t                 state_q;
	cmd_t                        cmd_q;
	logic [CELL_AW-1:0]          clr_q;
	logic                        dir_pot_q;
	logic signed [WEIGHT_W-1:0]  orig_q;
	logic signed [WEIGHT_W-1:0]  w_q;
	logic [TBL_AW-1:0]           p_q;
	logic [TBL_AW-1:0]           last_q;
	logic [PULSE_W-1:0]          pulses_q;
	logic signed [WEIGHT_W-1:0]  floor_q;
	logic signed [WEIGHT_W-1:0]  ceil_q;
	logic [TOTAL_W-1:0]          total_q;
	logic                        rsp_valid_q;
	logic signed [WEIGHT_W-1:0]  rsp_weight_q;
	logic [PULSES_W-1:0]         rsp_pulses_q;

	logic [WEIGHT_W-1:0]         pot_rd;
	logic [WEIGHT_W-1:0]         dep_rd;
	logic [WEIGHT_W:0]           cell_rd;
	logic [TBL_AW-1:0]           tbl_raddr;
	logic                        pot_we;
	logic                        dep_we;
	logic                        cell_we;
	logic [CELL_AW-1:0]          cell_waddr;
	logic [WEIGHT_W:0]           cell_wdata;

	logic signed [WEIGHT_W-1:0]  tval;
	logic signed [WEIGHT_W-1:0]  tgt;
	logic signed [WEIGHT_W-1:0]  orig;
	logic signed [WEIGHT_W-1:0]  entry;
	logic signed [WEIGHT_W-1:0]  w_floor;
	logic signed [WEIGHT_W-1:0]  w_clamp;
	logic [LEN_W-1:0]            len_sel;
	logic [TBL_AW:0]             n_walk;
	logic                        beyond;
	logic                        reached;
	logic                        fire;
	logic                        is_update;
	logic [TOTAL_W:0]            total_sum;

	assign tval      = cmd_q.value;
	assign tgt       = cmd_q.target;
	assign orig      = cell_rd[WEIGHT_W] ? cell_rd[WEIGHT_W-1:0] : pot_rd;
	assign entry     = dir_pot_q ? pot_rd : dep_rd;
	assign beyond    = dir_pot_q ? (entry > orig_q) : (entry < orig_q);
	assign reached   = dir_pot_q ? (entry >= tgt) : (entry <= tgt);
	assign is_update = (cmd_q.kind == CMD_UPDATE);
	assign fire      = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);

	// Walk length, limited to the table depth
	assign len_sel = (orig < tgt) ? lens.pot_len : lens.dep_len;
	assign n_walk  = (32'(len_sel) > TABLE_DEPTH) ? (TBL_AW + 1)'(TABLE_DEPTH) :
		(TBL_AW + 1)'(len_sel);

	// Clamp to floor first, then ceiling
	assign w_floor = (w_q < floor_q) ? floor_q : w_q;
	assign w_clamp = (w_floor > ceil_q) ? ceil_q : w_floor;

	assign total_sum = {1'b0, total_q} + (TOTAL_W + 1)'(pulses_q);

	// Read the entry after the one under test so data arrives each cycle
	assign tbl_raddr  = (state_q == ST_WALK) ? p_q + TBL_AW'(1) : '0;
	assign pot_we     = fire && (cmd_q.kind == CMD_LOAD_POT);
	assign dep_we     = fire && (cmd_q.kind == CMD_LOAD_DEP);
	assign cell_we    = (state_q == ST_CLEAR) || (fire && is_update);
	assign cell_waddr = (state_q == ST_CLEAR) ? clr_q : cmd_q.addr;
	assign cell_wdata = (state_q == ST_CLEAR) ? '0 : {1'b1, w_clamp};

	assign stat.pop      = (state_q == ST_IDLE) && head.valid;
	assign stat.clearing = (state_q == ST_CLEAR);

	assign rsp.valid          = rsp_valid_q;
	assign rsp.weight_out     = rsp_weight_q;
	assign rsp.pulses_applied = rsp_pulses_q;
	assign rsp.pulse_total    = total_q;

	rpwp_ram #(.WIDTH(WEIGHT_W), .DEPTH(TABLE_DEPTH)) u_pot_ram (
		.clk   (clk),
		.we    (pot_we),
		.waddr (cmd_q.idx),
		.wdata (cmd_q.value),
		.raddr (tbl_raddr),
		.rdata (pot_rd)
	);

	rpwp_ram #(.WIDTH(WEIGHT_W), .DEPTH(TABLE_DEPTH)) u_dep_ram (
		.clk   (clk),
		.we    (dep_we),
		.waddr (cmd_q.idx),
		.wdata (cmd_q.value),
		.raddr (tbl_raddr),
		.rdata (dep_rd)
	);

	// Cell weight with its written flag in the top bit
	rpwp_ram #(.WIDTH(WEIGHT_W + 1), .DEPTH(CELL_COUNT)) u_cell_ram (
		.clk   (clk),
		.we    (cell_we),
		.waddr (cell_waddr),
		.wdata (cell_wdata),
		.raddr (cmd_q.addr),
		.rdata (cell_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			floor_q     <= '0;
			ceil_q      <= '0;
			total_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == CELL_COUNT - 1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (head.valid) begin
						state_q <= (head.cmd.kind == CMD_UPDATE) ? ST_FETCH : ST_DONE;
					end
				end
				ST_FETCH: begin
					state_q <= ST_ORIG;
				end
				ST_ORIG: begin
					state_q <= (n_walk == '0) ? ST_DONE : ST_WALK;
				end
				ST_WALK: begin
					if ((beyond && reached) || p_q == last_q) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (fire) begin
						state_q <= ST_IDLE;
						if (cmd_q.kind == CMD_LOAD_POT || cmd_q.kind == CMD_LOAD_DEP) begin
							if (tval < floor_q) begin
								floor_q <= tval;
							end
							if (tval > ceil_q) begin
								ceil_q <= tval;
							end
						end
						if (is_update) begin
							total_q <= total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (head.valid) begin
					cmd_q    <= head.cmd;
					pulses_q <= '0;
				end
			end
			ST_ORIG: begin
				orig_q    <= orig;
				w_q       <= orig;
				dir_pot_q <= (orig < tgt);
				p_q       <= '0;
				last_q    <= TBL_AW'(n_walk - 1'b1);
			end
			ST_WALK: begin
				p_q <= p_q + 1'b1;
				if (beyond) begin
					pulses_q <= pulses_q + 1'b1;
					w_q      <= entry;
				end
			end
			ST_DONE: begin
				if (fire) begin
					rsp_weight_q <= is_update ? w_clamp : '0;
					rsp_pulses_q <= is_update ? PULSES_W'(pulses_q) : '0;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

/* hdl/reram_pulse_weight_programmer.sv */
`timescale 1ns / 1ps

// Channel | Role | Payload
// --------+------+------------------------------------------------------------------
// req     | sink | req_type, table_index, table_value, cell_address, target_weight
// rsp     | src  | weight_out, pulses_applied, pulse_total (one item per req item)
// cfg     | sink | index (0 pot_length, 1 dep_length), data
//
// Loads and ignored requests go from IDLE straight to DONE in the back end; an update
// passes through FETCH and ORIG, then walks the table entries (at most the selected
// length, capped at 64), one table memory read per cycle through the walk loop.
// After reset a clearing pass marks every one of the 1024 cells unwritten; req is
// held off meanwhile. cfg is always ready.
// A two-item queue sits between front and back, so req keeps accepting while a
// result waits on rsp; the back end holds its finished item until rsp frees up.
module reram_pulse_weight_programmer import rpwp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	rpwp_req_if.sink   req,
	rpwp_rsp_if.source rsp,
	rpwp_cfg_if.sink   cfg
);

	len_cfg_t    lens_q;
	queue_head_t head;
	back_stat_t  stat;

	// Length registers; writes to unknown indexes drop silently
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lens_q.pot_len <= LEN_RESET;
			lens_q.dep_len <= LEN_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_POT_LENGTH: lens_q.pot_len <= LEN_W'(cfg.data);
				CFG_DEP_LENGTH: lens_q.dep_len <= LEN_W'(cfg.data);
				default: begin
				end
			endcase
		end
	end

	// Front: classify and queue items
	rpwp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.stat   (stat),
		.head   (head)
	);

	// Back: table walk, clamping, write-back and result register
	rpwp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.lens   (lens_q),
		.head   (head),
		.stat   (stat),
		.rsp    (rsp)
	);

	// Running total never drops between consecutive results
	a_total_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.ready |=> !rsp.valid || rsp.pulse_total >= $past(rsp.pulse_total))
		else $error("pulse_total decreased");

	// Pulse count stays within one table walk
	a_pulses_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> 32'(rsp.pulses_applied) <= TABLE_DEPTH)
		else $error("pulses_applied above table depth");

	// A queued item stays until the back end pops it
	a_queue_holds: assert property (@(posedge clk) disable iff (!arst_n)
		head.valid && !stat.pop |=> head.valid)
		else $error("queued item lost");

	// No item enters while cells are being cleared
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |-> !req.ready)
		else $error("item accepted during clearing pass");

endmodule

/* bench/rpwp_monitor.sv */
`timescale 1ns / 1ps

module rpwp_monitor import rpwp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	rpwp_req_if  req,
	rpwp_rsp_if  rsp,
	rpwp_cfg_if  cfg,
	output int   fails,
	output int   pending
);

	typedef struct {
		logic signed [WEIGHT_W-1:0] weight;
		logic [PULSES_W-1:0]        pulses;
		logic [TOTAL_W-1:0]         total;
	} outcome_t;

	logic signed [WEIGHT_W-1:0] pot_steps [TABLE_DEPTH];
	logic signed [WEIGHT_W-1:0] dep_steps [TABLE_DEPTH];
	logic signed [WEIGHT_W-1:0] cell_weight [CELL_COUNT];
	bit                         cell_set [CELL_COUNT];
	logic [TOTAL_W-1:0]         total_pulses;
	logic signed [WEIGHT_W-1:0] floor_w;
	logic signed [WEIGHT_W-1:0] ceil_w;
	logic [LEN_W-1:0]           pot_len;
	logic [LEN_W-1:0]           dep_len;
	outcome_t                   due_results[$];
	int                         miss_count = 0;

	assign fails = miss_count;

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		miss_count++;
		$display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
	endtask

	// Apply one request to the shadow state and return the item it should produce.
	function automatic outcome_t program_step(input logic [REQ_W-1:0] kind,
			input logic [TIDX_W-1:0] idx, input logic signed [WEIGHT_W-1:0] value,
			input logic [ADDR_W-1:0] addr, input logic signed [WEIGHT_W-1:0] target);
		outcome_t                   o;
		logic signed [WEIGHT_W-1:0] orig;
		logic signed [WEIGHT_W-1:0] w;
		logic [TOTAL_W:0]           sum;
		int                         n;
		int                         hits;
		o.weight = '0;
		o.pulses = '0;
		case (kind) inside
			REQ_LOAD_POT, REQ_LOAD_DEP: begin
				if (kind == REQ_LOAD_POT) begin
					pot_steps[idx] = value;
				end else begin
					dep_steps[idx] = value;
				end
				if (value < floor_w) floor_w = value;
				if (value > ceil_w) ceil_w = value;
			end
			REQ_UPDATE: begin
				orig = cell_set[addr] ? cell_weight[addr] : pot_steps[0];
				w = orig;
				hits = 0;
				if (orig < target) begin
					n = (pot_len > TABLE_DEPTH) ? TABLE_DEPTH : int'(pot_len);
					for (int p = 0; p < n; p++) begin
						if (pot_steps[p] > orig) begin
							hits++;
							w = pot_steps[p];
							if (w >= target) break;
						end
					end
				end else begin
					// equal target lands here: depression walk
					n = (dep_len > TABLE_DEPTH) ? TABLE_DEPTH : int'(dep_len);
					for (int p = 0; p < n; p++) begin
						if (dep_steps[p] < orig) begin
							hits++;
							w = dep_steps[p];
							if (w <= target) break;
						end
					end
				end
				if (w < floor_w) w = floor_w;
				if (w > ceil_w) w = ceil_w;
				cell_weight[addr] = w;
				cell_set[addr] = 1'b1;
				o.weight = w;
				o.pulses = PULSES_W'(hits);
				sum = {1'b0, total_pulses} + (TOTAL_W + 1)'(hits);
				total_pulses = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
			end
			default: begin
			end
		endcase
		o.total = total_pulses;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		outcome_t want;
		if (!arst_n) begin
			for (int i = 0; i < CELL_COUNT; i++) cell_set[i] = 1'b0;
			total_pulses = '0;
			floor_w = '0;
			ceil_w = '0;
			pot_len = LEN_RESET;
			dep_len = LEN_RESET;
			due_results.delete();
			pending <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_POT_LENGTH: pot_len = cfg.data;
					CFG_DEP_LENGTH: dep_len = cfg.data;
					default: begin
					end
				endcase
			end
			if (req.valid && req.ready) begin
				due_results = {due_results, program_step(req.req_type, req.table_index,
					req.table_value, req.cell_address, req.target_weight)};
			end
			if (rsp.valid && rsp.ready) begin
				if (due_results.size() == 0) begin
					flag_mismatch("item with nothing pending", longint'(rsp.weight_out), 0);
				end else begin
					want = due_results.pop_front();
					if (rsp.weight_out !== want.weight)
						flag_mismatch("weight_out", longint'(rsp.weight_out),
							longint'(want.weight));
					if (rsp.pulses_applied !== want.pulses)
						flag_mismatch("pulses_applied", longint'(rsp.pulses_applied),
							longint'(want.pulses));
					if (rsp.pulse_total !== want.total)
						flag_mismatch("pulse_total", longint'(rsp.pulse_total),
							longint'(want.total));
				end
			end
			pending <= due_results.size();
		end
	end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
	import rpwp_pkg::*;

	// Register indexes past the two real ones; writes there must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
	// Request code the block has to ignore.
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	// Longest update in the back end: fixed overhead plus a full table walk.
	localparam int WALK_CYCLES = 4 + TABLE_DEPTH;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 100;

	logic clk = 1'b0;
	logic arst_n;
	int   fails;
	int   pending;
	bit   calm = 1'b0;   // set: neither side idles
	int   rsp_hold = 0;

	// What the stimulus has loaded so far; a walk must never touch an unloaded entry.
	logic [LEN_W-1:0]           pot_len_now = LEN_RESET;
	logic [LEN_W-1:0]           dep_len_now = LEN_RESET;
	bit                         pot_loaded [TABLE_DEPTH];
	bit                         dep_loaded [TABLE_DEPTH];
	logic signed [WEIGHT_W-1:0] pot_vals [TABLE_DEPTH];
	logic signed [WEIGHT_W-1:0] dep_vals [TABLE_DEPTH];

	// Length settings per random phase: extremes, zero and beyond-depth among them.
	int pot_set [PHASES] = '{64, 1, 127, 0, 64, 33, 127, 5};
	int dep_set [PHASES] = '{64, 1, 127, 64, 0, 12, 96, 2};

	rpwp_req_if req_ch ();
	rpwp_rsp_if rsp_ch ();
	rpwp_cfg_if cfg_ch ();

	reram_pulse_weight_programmer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	rpwp_monitor u_monitor (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.cfg     (cfg_ch),
		.fails   (fails),
		.pending (pending)
	);

	always #6 clk = ~clk;

	// Mostly short pauses, now and then a long one.
	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 19);
		if (r < 12) return $urandom_range(1, 2);
		if (r < 18) return $urandom_range(3, 8);
		return $urandom_range(20, 45);
	endfunction

	function automatic int req_gap();
		if (calm) return 0;
		return $urandom_range(0, 1) ? 0 : pause_len();
	endfunction

	// Receiver side: stall at random unless in a calm stretch.
	always @(posedge clk) begin
		if (rsp_hold > 0) begin
			rsp_ch.ready <= 1'b0;
			rsp_hold--;
		end else begin
			rsp_ch.ready <= 1'b1;
			if (!calm && $urandom_range(0, 3) == 0) rsp_hold = pause_len();
		end
	end

	// True when every entry either walk could reach has been loaded.
	function automatic bit walk_ok();
		int n;
		n = (pot_len_now > dep_len_now) ? int'(pot_len_now) : int'(dep_len_now);
		if (n > TABLE_DEPTH) n = TABLE_DEPTH;
		if (!pot_loaded[0]) return 1'b0;
		for (int i = 0; i < n; i++) begin
			if (!pot_loaded[i] || !dep_loaded[i]) return 1'b0;
		end
		return 1'b1;
	endfunction

	// Present one item, hold it until accepted. Called and returns at a rising edge.
	task automatic push_req(input logic [REQ_W-1:0] kind, input logic [TIDX_W-1:0] idx,
			input logic signed [WEIGHT_W-1:0] value, input logic [ADDR_W-1:0] addr,
			input logic signed [WEIGHT_W-1:0] target);
		int gap;
		gap = req_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.req_type      <= kind;
		req_ch.table_index   <= idx;
		req_ch.table_value   <= value;
		req_ch.cell_address  <= addr;
		req_ch.target_weight <= target;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		if (kind == REQ_LOAD_POT) begin
			pot_loaded[idx] = 1'b1;
			pot_vals[idx] = value;
		end else if (kind == REQ_LOAD_DEP) begin
			dep_loaded[idx] = 1'b1;
			dep_vals[idx] = value;
		end
	endtask

	// Update with don't-care load fields randomized.
	task automatic push_update(input logic [ADDR_W-1:0] addr,
			input logic signed [WEIGHT_W-1:0] target);
		push_req(REQ_UPDATE, TIDX_W'($urandom), WEIGHT_W'($urandom), addr, target);
	endtask

	// Drop valid and hold off until every pending item has come back.
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Registers change only with the block idle.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		if (idx == CFG_POT_LENGTH) begin
			pot_len_now = data;
		end else if (idx == CFG_DEP_LENGTH) begin
			dep_len_now = data;
		end
	endtask

	// Load a whole table as a realistic pulse curve: rising for potentiation,
	// falling for depression, random step sizes with some flat steps.
	task automatic load_ramp(input logic [REQ_W-1:0] kind);
		int v;
		bit up;
		up = (kind == REQ_LOAD_POT);
		v = up ? -32768 + int'($urandom_range(0, 6000)) : 32767 - int'($urandom_range(0, 6000));
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			push_req(kind, TIDX_W'(i), WEIGHT_W'(v), ADDR_W'($urandom), WEIGHT_W'($urandom));
			v = up ? v + int'($urandom_range(0, 950)) : v - int'($urandom_range(0, 950));
			if (v > 32767) v = 32767;
			if (v < -32768) v = -32768;
		end
	endtask

	// Pick a target: mostly anywhere, sometimes exactly on a table entry or a rail.
	function automatic logic signed [WEIGHT_W-1:0] pick_target();
		int r;
		int i;
		r = $urandom_range(0, 19);
		i = $urandom_range(0, TABLE_DEPTH - 1);
		if (r < 12) return WEIGHT_W'($urandom);
		if (r < 15 && pot_loaded[i]) return pot_vals[i];
		if (r < 18 && dep_loaded[i]) return dep_vals[i];
		if (r == 18) return 16'sh7FFF;
		return 16'sh8000;
	endfunction

	task automatic random_item();
		int pick;
		logic [ADDR_W-1:0] addr;
		pick = $urandom_range(0, 99);
		// a small pool of cells gets reprogrammed over and over
		addr = $urandom_range(0, 2) == 0 ? ADDR_W'($urandom_range(0, 15)) : ADDR_W'($urandom);
		if (pick < 85 && walk_ok()) begin
			push_update(addr, pick_target());
		end else if (pick < 95) begin
			// noise: stray load that breaks the curve shape
			push_req($urandom_range(0, 1) ? REQ_LOAD_POT : REQ_LOAD_DEP, TIDX_W'($urandom),
				WEIGHT_W'($urandom), addr, WEIGHT_W'($urandom));
		end else begin
			push_req(REQ_UNUSED, TIDX_W'($urandom), WEIGHT_W'($urandom), addr,
				WEIGHT_W'($urandom));
		end
	endtask

	initial begin
		arst_n               <= 1'b0;
		req_ch.valid         <= 1'b0;
		req_ch.req_type      <= '0;
		req_ch.table_index   <= '0;
		req_ch.table_value   <= '0;
		req_ch.cell_address  <= '0;
		req_ch.target_weight <= '0;
		cfg_ch.valid         <= 1'b0;
		cfg_ch.index         <= '0;
		cfg_ch.data          <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, lengths at reset (1). Floor and ceiling stay narrow at first.
		push_req(REQ_LOAD_POT, '0, 16'sh0800, '0, '0);
		push_req(REQ_LOAD_DEP, '0, 16'shF800, '0, '0);
		// unwritten cell starts from potentiation entry 0, already at the top
		push_update('0, 16'sh7FFF);
		// walk down to the only depression entry, short of the target
		push_update('0, 16'sh8000);
		// equal target: depression walk with nothing below
		push_update('0, 16'shF800);
		push_update(10'd1023, 16'sh0800);
		push_req(REQ_UNUSED, '1, '1, '1, '1);
		// zero length: no walk, only the clamp
		write_reg(CFG_POT_LENGTH, '0);
		write_reg(CFG_DEP_LENGTH, '0);
		push_update(10'd2, 16'sh7FFF);
		push_update(10'd1023, 16'sh8000);
		// field extremes, including the last table index
		push_req(REQ_LOAD_POT, 6'd1, 16'sh7FFF, '0, '0);
		push_req(REQ_LOAD_DEP, 6'd1, 16'sh8000, '0, '0);
		push_req(REQ_LOAD_POT, 6'd63, 16'sh8000, '1, '1);
		push_req(REQ_LOAD_DEP, 6'd63, 16'sh7FFF, '1, '1);
		write_reg(CFG_POT_LENGTH, 7'd2);
		write_reg(CFG_DEP_LENGTH, 7'd2);
		push_update(10'd3, 16'sh7FFF);
		push_update(10'd3, 16'sh8000);
		push_update(10'd3, '0);
		push_update(10'd1022, 16'sh0801);

		// Fill both tables with well-formed curves so any length is safe to walk.
		load_ramp(REQ_LOAD_POT);
		load_ramp(REQ_LOAD_DEP);

		// Random phases, each under its own length setting.
		for (int ph = 0; ph < PHASES; ph++) begin
			write_reg(CFG_POT_LENGTH, CFG_DATA_W'(pot_set[ph]));
			write_reg(CFG_DEP_LENGTH, CFG_DATA_W'(dep_set[ph]));
			if (ph == 2) begin
				write_reg(CFG_SPARE_LO, '1);
				write_reg(CFG_SPARE_HI, '0);
			end
			calm = (ph % 3 == 1);
			if ($urandom_range(0, 1)) load_ramp($urandom_range(0, 1) ? REQ_LOAD_POT : REQ_LOAD_DEP);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// hold the sender until everything is back, mid-phase
				if (ph == 4 && n == PHASE_ITEMS / 2) drain();
				random_item();
			end
		end

		drain();
		repeat (WALK_CYCLES) @(posedge clk);
		if (fails == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Hard stop: far beyond the slowest legal run.
	initial begin
		#12_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

/* filelist.f */
hdl/rpwp_pkg.sv
hdl/rpwp_if.sv
hdl/rpwp_ram.sv
hdl/rpwp_front.sv
hdl/rpwp_back.sv
hdl/reram_pulse_weight_programmer.sv
bench/rpwp_monitor.sv
bench/tb.sv
